>>> rtl/zrbe_pkg.sv
`timescale 1ns / 1ps
package zrbe_pkg;

  localparam logic [7:0] ZERO_BYTE  = 8'd0;
  localparam logic [7:0] CHUNK_BYTE = 8'd255;
  localparam logic [7:0] SPLIT_BYTE = 8'd200;

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_MARK   = 9'b000000010,
    ST_CHUNK  = 9'b000000100,
    ST_SPLITA = 9'b000001000,
    ST_SPLITB = 9'b000010000,
    ST_REM    = 9'b000100000,
    ST_LEAD   = 9'b001000000,
    ST_TERMA  = 9'b010000000,
    ST_TERMB  = 9'b100000000
  } state_t;

  typedef enum logic [2:0] {
    SEL_ZERO  = 3'd0,
    SEL_CHUNK = 3'd1,
    SEL_SPLIT = 3'd2,
    SEL_RUN   = 3'd3,
    SEL_LEAD  = 3'd4
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_sel_t sel;
    logic      done;
    logic      fin;
    logic      run_sub_chunk;
    logic      run_sub_split;
    logic      run_clr;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
    logic in_zero;
    logic in_last;
    logic last_q;
    logic run_zero;
    logic run_gt;
    logic run_eq;
    logic sub_gt;
    logic sub_eq;
  } status_t;

endpackage

>>> rtl/zrbe_ctrl.sv
`timescale 1ns / 1ps
module zrbe_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  zrbe_pkg::status_t sts,
  output zrbe_pkg::cmd_t   cmd
);

  zrbe_pkg::state_t state;
  zrbe_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= zrbe_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next        = state;
    s_tready          = 1'b0;
    cmd               = '0;
    cmd.sel           = zrbe_pkg::SEL_ZERO;
    case (state)
      zrbe_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load = 1'b1;
          if (!sts.in_zero) begin
            state_next = sts.run_zero ? zrbe_pkg::ST_LEAD : zrbe_pkg::ST_MARK;
          end else if (sts.in_last) begin
            state_next = zrbe_pkg::ST_TERMA;
          end
        end
      end
      zrbe_pkg::ST_MARK: begin
        cmd.sel = zrbe_pkg::SEL_ZERO;
        if (sts.slot_free) begin
          cmd.emit = 1'b1;
          if (sts.run_gt) begin
            state_next = zrbe_pkg::ST_CHUNK;
          end else if (sts.run_eq) begin
            state_next = zrbe_pkg::ST_SPLITA;
          end else begin
            state_next = zrbe_pkg::ST_REM;
          end
        end
      end
      zrbe_pkg::ST_CHUNK: begin
        cmd.sel = zrbe_pkg::SEL_CHUNK;
        if (sts.slot_free) begin
          cmd.emit          = 1'b1;
          cmd.run_sub_chunk = 1'b1;
          if (sts.sub_gt) begin
            state_next = zrbe_pkg::ST_CHUNK;
          end else if (sts.sub_eq) begin
            state_next = zrbe_pkg::ST_SPLITA;
          end else begin
            state_next = zrbe_pkg::ST_REM;
          end
        end
      end
      zrbe_pkg::ST_SPLITA: begin
        cmd.sel = zrbe_pkg::SEL_SPLIT;
        if (sts.slot_free) begin
          cmd.emit          = 1'b1;
          cmd.run_sub_split = 1'b1;
          state_next        = zrbe_pkg::ST_SPLITB;
        end
      end
      zrbe_pkg::ST_SPLITB: begin
        cmd.sel = zrbe_pkg::SEL_ZERO;
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = zrbe_pkg::ST_REM;
        end
      end
      zrbe_pkg::ST_REM: begin
        cmd.sel = zrbe_pkg::SEL_RUN;
        if (sts.slot_free) begin
          cmd.emit    = 1'b1;
          cmd.run_clr = 1'b1;
          state_next  = zrbe_pkg::ST_LEAD;
        end
      end
      zrbe_pkg::ST_LEAD: begin
        cmd.sel  = zrbe_pkg::SEL_LEAD;
        cmd.done = !sts.last_q;
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = sts.last_q ? zrbe_pkg::ST_TERMA : zrbe_pkg::ST_IDLE;
        end
      end
      zrbe_pkg::ST_TERMA: begin
        cmd.sel = zrbe_pkg::SEL_ZERO;
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = zrbe_pkg::ST_TERMB;
        end
      end
      zrbe_pkg::ST_TERMB: begin
        cmd.sel  = zrbe_pkg::SEL_ZERO;
        cmd.done = 1'b1;
        cmd.fin  = 1'b1;
        if (sts.slot_free) begin
          cmd.emit   = 1'b1;
          state_next = zrbe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = zrbe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/zrbe_dpath.sv
`timescale 1ns / 1ps
module zrbe_dpath #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        s_tdata,
  input  logic              s_tlast,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [7:0]        m_tdata,
  output logic              m_tlast,
  output logic              m_tuser,
  input  zrbe_pkg::cmd_t    cmd,
  output zrbe_pkg::status_t sts
);

  localparam int RunW = $clog2(MAX_ENTRIES + 1);
  localparam logic [RunW-1:0] RunMax   = RunW'(MAX_ENTRIES);
  localparam logic [RunW-1:0] RunChunk = RunW'(255);
  localparam logic [RunW-1:0] RunSplit = RunW'(200);
  localparam logic [RunW-1:0] RunTwo   = RunW'(510);

  logic [RunW-1:0] run;
  logic [7:0]      lead;
  logic            last;
  logic [7:0]      byte_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (cmd.load && s_tdata == zrbe_pkg::ZERO_BYTE) begin
      if (s_tlast) begin
        run <= '0;
      end else if (run < RunMax) begin
        run <= run + RunW'(1);
      end
    end else if (cmd.run_sub_chunk) begin
      run <= run - RunChunk;
    end else if (cmd.run_sub_split) begin
      run <= run - RunSplit;
    end else if (cmd.run_clr) begin
      run <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lead <= s_tdata;
      last <= s_tlast;
    end
  end

  always_comb begin
    case (cmd.sel)
      zrbe_pkg::SEL_ZERO:  byte_next = zrbe_pkg::ZERO_BYTE;
      zrbe_pkg::SEL_CHUNK: byte_next = zrbe_pkg::CHUNK_BYTE;
      zrbe_pkg::SEL_SPLIT: byte_next = zrbe_pkg::SPLIT_BYTE;
      zrbe_pkg::SEL_RUN:   byte_next = run[7:0];
      zrbe_pkg::SEL_LEAD:  byte_next = lead;
      default:             byte_next = zrbe_pkg::ZERO_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tdata <= byte_next;
      m_tlast <= cmd.done;
      m_tuser <= cmd.fin;
    end
  end

  always_comb begin
    sts.slot_free = !m_tvalid || m_tready;
    sts.in_zero   = (s_tdata == zrbe_pkg::ZERO_BYTE);
    sts.in_last   = s_tlast;
    sts.last_q    = last;
    sts.run_zero  = (run == '0);
    sts.run_gt    = (run > RunChunk);
    sts.run_eq    = (run == RunChunk);
    sts.sub_gt    = (run > RunTwo);
    sts.sub_eq    = (run == RunTwo);
  end

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("item written over a held result");

  a_run_bound: assert property (@(posedge clk) disable iff (rst)
    run <= RunMax)
    else $error("zero run above its limit");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("stream end without item end");

  a_split_rem: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.run_sub_split) |-> (run == RunW'(55)))
    else $error("split remainder wrong");

endmodule

>>> rtl/zero_run_byte_encoder_top.sv
`timescale 1ns / 1ps
// Channel  Dir  Fields
// s_*      in   tdata[7:0] lead_byte, tlast final_entry
// m_*      out  tdata[7:0] code_byte, tlast item_done, tuser stream_end
//
// A zero, non-final item is taken every cycle and adds nothing to the output.
// Any other item holds the input until all its bytes are emitted: one for a
// plain byte, 3 + chunk count (+2 on split) at a run end, 2 more when final.
// The state machine emits one byte per cycle while the output is not stalled.
// Reset clears the run count, the state and the output valid.
// A stall on m_tready holds the state; the input is taken only in idle.
module zero_run_byte_encoder_top #(
  parameter int MAX_ENTRIES = 4096
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] lead_byte
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] code_byte
  output logic       m_tlast,
  output logic       m_tuser    // [0] stream_end
);

  zrbe_pkg::cmd_t    cmd;
  zrbe_pkg::status_t sts;

  zrbe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  zrbe_dpath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .sts      (sts)
  );

endmodule

>>> test/tb_zero_run_byte_encoder_top.sv
`timescale 1ns / 1ps
module tb_zero_run_byte_encoder_top;

  localparam int RUN_CEILING = 4096;
  localparam int CYCLE_LIMIT = 600000;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  typedef struct packed {
    logic [7:0] code;
    logic       done;
    logic       stream_end;
  } code_item_t;

  class code_scoreboard;
    code_item_t  expected_codes[$];
    logic [12:0] zero_run;
    int          errors;

    function new();
      zero_run = '0;
      errors   = 0;
    endfunction

    function void push_code(logic [7:0] code);
      code_item_t c;
      c.code       = code;
      c.done       = 1'b0;
      c.stream_end = 1'b0;
      expected_codes.push_back(c);
    endfunction

    function void note_input(logic [7:0] lead, logic fin);
      logic [12:0] run;
      int          base_count;
      base_count = expected_codes.size();
      if (lead != zrbe_pkg::ZERO_BYTE) begin
        if (zero_run != 0) begin
          run = zero_run;
          push_code(zrbe_pkg::ZERO_BYTE);
          while (run > 13'(zrbe_pkg::CHUNK_BYTE)) begin
            push_code(zrbe_pkg::CHUNK_BYTE);
            run = run - 13'(zrbe_pkg::CHUNK_BYTE);
          end
          if (run == 13'(zrbe_pkg::CHUNK_BYTE)) begin
            push_code(zrbe_pkg::SPLIT_BYTE);
            push_code(zrbe_pkg::ZERO_BYTE);
            run = run - 13'(zrbe_pkg::SPLIT_BYTE);
          end
          push_code(run[7:0]);
          zero_run = '0;
        end
        push_code(lead);
      end else if (zero_run < 13'(RUN_CEILING)) begin
        zero_run = zero_run + 1'b1;
      end
      if (fin) begin
        push_code(zrbe_pkg::ZERO_BYTE);
        push_code(zrbe_pkg::ZERO_BYTE);
        expected_codes[expected_codes.size() - 1].stream_end = 1'b1;
        zero_run = '0;
      end
      if (expected_codes.size() > base_count)
        expected_codes[expected_codes.size() - 1].done = 1'b1;
    endfunction

    function void check_result(logic [7:0] code, logic done, logic stream_end);
      code_item_t want;
      if (expected_codes.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: expected none, got code %0d done %0b end %0b",
                 $time, code, done, stream_end);
        return;
      end
      want = expected_codes.pop_front();
      if (code !== want.code) begin
        errors++;
        $display("%0t: code_byte: expected %0d, got %0d", $time, want.code, code);
      end
      if (done !== want.done) begin
        errors++;
        $display("%0t: item_done: expected %0b, got %0b", $time, want.done, done);
      end
      if (stream_end !== want.stream_end) begin
        errors++;
        $display("%0t: stream_end: expected %0b, got %0b", $time, want.stream_end,
                 stream_end);
      end
    endfunction

    function int outstanding();
      return expected_codes.size();
    endfunction
  endclass

  logic       clk;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  logic       m_tuser;

  code_scoreboard sb;
  int             send_idle_pct;
  int             recv_stall_pct;
  logic           hold_req;
  int             cycle_count;

  zero_run_byte_encoder_top #(
    .MAX_ENTRIES(RUN_CEILING)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tlast (s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready)
        sb.check_result(m_tdata, m_tlast, m_tuser);
      if (s_tvalid && s_tready)
        sb.note_input(s_tdata, s_tlast);
    end
  end

  // receiver: random stalls, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] lead, input logic fin);
    logic taken;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= lead;
    s_tlast  <= fin;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = s_tready;
      @(negedge clk);
    end
  endtask

  task automatic send_zeros(input int count);
    repeat (count) send_item(zrbe_pkg::ZERO_BYTE, 1'b0);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  task automatic send_random_entry();
    int          pick;
    int          run_len;
    logic [7:0]  lead;
    logic        fin;
    pick = $urandom_range(99);
    if (pick < 45)      run_len = 0;
    else if (pick < 80) run_len = $urandom_range(6, 1);
    else                run_len = $urandom_range(12, 7);
    send_zeros(run_len);
    lead = ($urandom_range(99) < 10) ? zrbe_pkg::ZERO_BYTE : 8'($urandom_range(255, 1));
    fin  = ($urandom_range(99) < 8);
    if (lead == zrbe_pkg::ZERO_BYTE)
      fin = ($urandom_range(99) < 60);
    send_item(lead, fin);
  endtask

  initial begin
    sb             = new();
    rst            = 1'b1;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tlast        = 1'b0;
    hold_req       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    send_item(8'h01, 1'b0);
    send_item(8'hFF, 1'b0);
    send_zeros(1);
    send_item(8'h80, 1'b0);
    send_zeros(3);
    send_item(8'h55, 1'b1);
    send_zeros(3);
    send_item(zrbe_pkg::ZERO_BYTE, 1'b1);
    send_item(zrbe_pkg::ZERO_BYTE, 1'b1);
    send_zeros(2);
    send_item(8'h10, 1'b1);
    send_zeros(6);
    send_item(8'hAA, 1'b0);

    // pause until the block has emptied
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 47;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 47;
        end
        default: begin
          send_idle_pct  = 27;
          recv_stall_pct = 27;
        end
      endcase
      for (int i = 0; i < 12; i++) begin
        if (phase == 0 && i == 2)
          hold_req = 1'b1;
        send_random_entry();
      end
    end
    s_tvalid <= 1'b0;

    while (sb.outstanding() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
